### rtl/itrt_pkg.sv
`timescale 1ns / 1ps
// itrt_pkg: types, constants and the digit-to-ASCII mapping for integer_to_radix_text.
// No dependencies; imported by itrt_divider and integer_to_radix_text.
package itrt_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int RADIX_W     = 6;
    localparam int CHAR_W      = 7;
    localparam int DIGIT_W     = 6;
    localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
    localparam int ADDR_W      = $clog2(VALUE_WIDTH);

    localparam logic [RADIX_W-1:0] RADIX_MIN      = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX      = 6'd36;
    localparam logic [DIGIT_W-1:0] DECIMAL_DIGITS = 6'd10;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;  // '0'
    localparam logic [CHAR_W-1:0] CHAR_A     = 7'h41;  // 'A'
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;  // '-'
    localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'h00;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] value;
        logic [RADIX_W-1:0]            radix;
    } num_t;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
        logic              bad_radix;
    } char_t;

    // divider control and status
    typedef struct packed {
        logic start;   // load a new dividend
        logic resume;  // divide the previous quotient again
    } div_ctrl_t;

    typedef struct packed {
        logic               done;
        logic               quot_zero;
        logic [DIGIT_W-1:0] remainder;
    } div_sts_t;

    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        dx = {1'b0, d};
        if (d < DECIMAL_DIGITS)
            return CHAR_ZERO + dx;
        else
            return CHAR_A + dx - {1'b0, DECIMAL_DIGITS};
    endfunction

endpackage

### rtl/itrt_divider.sv
`timescale 1ns / 1ps
// itrt_divider: bit-serial restoring divider, one quotient bit per cycle.
// Depends on itrt_pkg.
module itrt_divider (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  itrt_pkg::div_ctrl_t                   ctrl,
    input  logic [itrt_pkg::VALUE_WIDTH-1:0]      dividend,
    input  logic [itrt_pkg::RADIX_W-1:0]          radix,
    output itrt_pkg::div_sts_t                    sts
);
    import itrt_pkg::*;

    logic                   busy_reg,  busy_next;
    logic [CNT_W-1:0]       cnt_reg,   cnt_next;
    logic [VALUE_WIDTH-1:0] work_reg,  work_next;  // dividend in, quotient out
    logic [DIGIT_W-1:0]     rem_reg,   rem_next;
    logic                   q_any_reg, q_any_next;

    logic               done;
    logic [DIGIT_W:0]   rem_shift;
    logic               ge;

    assign done      = busy_reg && (cnt_reg == CNT_W'(VALUE_WIDTH));
    assign rem_shift = {rem_reg, work_reg[VALUE_WIDTH-1]};
    assign ge        = rem_shift >= {1'b0, radix};

    always_comb
    begin
        busy_next  = busy_reg;
        cnt_next   = cnt_reg;
        work_next  = work_reg;
        rem_next   = rem_reg;
        q_any_next = q_any_reg;
        if (ctrl.start || ctrl.resume)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            rem_next   = '0;
            q_any_next = 1'b0;
            if (ctrl.start)
                work_next = dividend;
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end
        else if (busy_reg)
        begin
            rem_next   = ge ? DIGIT_W'(rem_shift - {1'b0, radix}) : rem_shift[DIGIT_W-1:0];
            work_next  = {work_reg[VALUE_WIDTH-2:0], ge};
            q_any_next = q_any_reg | ge;
            cnt_next   = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            cnt_reg   <= '0;
            q_any_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            cnt_reg   <= cnt_next;
            q_any_reg <= q_any_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
    end

    assign sts.done      = done;
    assign sts.quot_zero = !q_any_reg;
    assign sts.remainder = rem_reg;

endmodule

### rtl/integer_to_radix_text.sv
`timescale 1ns / 1ps
// integer_to_radix_text: top level; control sequencer, digit store and output register.
// Depends on itrt_pkg and itrt_divider.
//
// Converts a signed VALUE_WIDTH-bit integer to ASCII text in base 2..36, one character per
// output transaction: '-' first for a negative value, then the digits most significant
// first ('0'-'9', 'A'-'Z'), with last set on the final character. Zero gives "0". The
// most negative value converts correctly. A radix outside 2..36 gives a single
// transaction with character 0, last 1 and bad_radix 1. The block takes one number at a
// time. Each digit costs one pass of the bit-serial divider. Once the quotient is zero,
// the sign goes out first for a negative value, then each digit takes a memory read and
// an output load, the load waiting while the output is stalled. The input is accepted
// again as soon as the last character sits in the output register.
module integer_to_radix_text (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            num_valid,
    output logic            num_ready,
    input  itrt_pkg::num_t  num_data,
    output logic            char_valid,
    input  logic            char_ready,
    output itrt_pkg::char_t char_data
);
    import itrt_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_ERR  = 3'd2;
    localparam logic [2:0] S_SIGN = 3'd3;
    localparam logic [2:0] S_READ = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic               neg_reg,   neg_next;
    logic [RADIX_W-1:0] radix_reg, radix_next;
    logic [CNT_W-1:0]   cnt_reg,   cnt_next;     // digits held in the store
    logic               out_valid_reg, out_valid_next;
    char_t              out_reg,   out_next;

    // digit store, written low digit first, read back from the top
    logic [DIGIT_W-1:0] digit_mem [VALUE_WIDTH];
    logic [DIGIT_W-1:0] rd_data_reg;
    logic               mem_we;
    logic               mem_re;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr;

    div_ctrl_t              div_ctrl;
    div_sts_t               div_sts;
    logic [VALUE_WIDTH-1:0] magnitude;

    logic accept;
    logic out_free;
    logic bad;

    assign num_ready = (state_reg == S_IDLE);
    assign accept    = num_valid && num_ready;
    assign out_free  = !out_valid_reg || char_ready;
    assign bad       = (num_data.radix < RADIX_MIN) || (num_data.radix > RADIX_MAX);

    // unsigned magnitude; the most negative value maps to 2^(VALUE_WIDTH-1)
    assign magnitude = num_data.value[VALUE_WIDTH-1] ? (~num_data.value + 1'b1)
                                                      : num_data.value;

    assign wr_addr = cnt_reg[ADDR_W-1:0];
    assign rd_addr = ADDR_W'(cnt_reg - 1'b1);

    itrt_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (magnitude),
        .radix    (radix_reg),
        .sts      (div_sts)
    );

    always_comb
    begin
        state_next     = state_reg;
        neg_next       = neg_reg;
        radix_next     = radix_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !char_ready;
        out_next       = out_reg;
        div_ctrl       = '0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    neg_next   = num_data.value[VALUE_WIDTH-1];
                    radix_next = num_data.radix;
                    cnt_next   = '0;
                    if (bad)
                        state_next = S_ERR;
                    else
                    begin
                        div_ctrl.start = 1'b1;
                        state_next     = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (div_sts.done)
                begin
                    mem_we   = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    if (div_sts.quot_zero)
                        state_next = neg_reg ? S_SIGN : S_READ;
                    else
                        div_ctrl.resume = 1'b1;
                end
            end
            S_ERR:
            begin
                if (out_free)
                begin
                    out_valid_next     = 1'b1;
                    out_next.character = CHAR_NONE;
                    out_next.last      = 1'b1;
                    out_next.bad_radix = 1'b1;
                    state_next         = S_IDLE;
                end
            end
            S_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next     = 1'b1;
                    out_next.character = CHAR_MINUS;
                    out_next.last      = 1'b0;
                    out_next.bad_radix = 1'b0;
                    state_next         = S_READ;
                end
            end
            S_READ:
            begin
                mem_re     = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next     = 1'b1;
                    out_next.character = digit_to_char(rd_data_reg);
                    out_next.last      = (cnt_reg == CNT_W'(1));
                    out_next.bad_radix = 1'b0;
                    cnt_next           = cnt_reg - 1'b1;
                    state_next         = (cnt_reg == CNT_W'(1)) ? S_IDLE : S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg   <= neg_next;
        radix_reg <= radix_next;
        out_reg   <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            digit_mem[wr_addr] <= div_sts.remainder;
        if (mem_re)
            rd_data_reg <= digit_mem[rd_addr];
    end

    assign char_valid = out_valid_reg;
    assign char_data  = out_reg;

    // an error transaction is always the only, hence last, one
    a_bad_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && char_data.bad_radix |-> char_data.last)
        else $error("bad_radix transaction without last");

    // a number never needs more digits than VALUE_WIDTH
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(VALUE_WIDTH))
        else $error("digit count overflow");

    // the store is never read empty
    a_read_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |-> cnt_reg != '0)
        else $error("digit store read while empty");

    // divider results only show up while the sequencer waits for them
    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_sts.done |-> state_reg == S_DIV)
        else $error("divider finished outside divide phase");

endmodule
